// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion helper macros for the multipole projection block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

// ----- design/lmp_pkg.sv -----
// ---------------------------------------------------------------------------
// lmp_pkg
// Types and constants shared by the multipole projection block.
// ---------------------------------------------------------------------------
package lmp_pkg;

  // Fraction bits of the Q16.16 data and the Q1.16 mu and bin width
  localparam int FRAC_BITS = 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POLY1, ST_POLY2, ST_WEIGHT, ST_KMUL,
    ST_TERM, ST_ACC, ST_SQRT, ST_OUT
  } lmp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       load;      // capture the input item
    logic       poly1;     // m2 = mu^2
    logic       poly2;     // m4 = m2^2
    logic       weight;    // form weights
    logic       kmul;      // k = w * bin width
    logic       term;      // products with value and error
    logic       acc;       // add into sums
    logic       sqrt_start;
    logic       sqrt_step;
    logic       emit;      // load output register, clear sums
    logic [1:0] sel;       // which order is being processed
  } lmp_cmd_t;

  typedef struct packed {
    logic last;
    logic sqrt_done;
  } lmp_stat_t;

  localparam int SQRT_STEPS = 32;

endpackage

// ----- design/legendre_multipole_projection.sv -----
// ---------------------------------------------------------------------------
// legendre_multipole_projection
// Orders 0, 2, 4 Legendre projection of one radial row, fixed point.
// ---------------------------------------------------------------------------
// Each mu bin runs, from its transfer to the next, through three polynomial
// steps, three passes of weight-times-bin-width, value and error products and
// sum update through a single product stage, a closing state and the idle
// state in which the next bin is taken. The bin that ends a row adds 32
// bit-serial square root steps (one root bit per cycle once the last sum
// update has landed, all three in parallel), a completion check and the output
// load. A bin that does not end a row is taken while a result waits; a
// row-ending bin holds in the root stage until the output register has been emptied.
`include "assert_macros.svh"
module legendre_multipole_projection
  import lmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        radius,
  input  logic signed [17:0] mu_value,
  input  logic signed [31:0] corr_value,
  input  logic [30:0]        corr_error,
  input  logic               row_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        radius_out,
  output logic signed [31:0] monopole,
  output logic signed [31:0] quadrupole,
  output logic signed [31:0] hexadecapole,
  output logic [31:0]        mono_error,
  output logic [31:0]        quad_error,
  output logic [31:0]        hexa_error
);

  lmp_cmd_t    cmd;
  lmp_stat_t   stat;
  logic [16:0] bin_width;

  // Bin width register
  always_ff @(posedge clk) begin
    if (rst) bin_width <= 17'd6554;
    else if (cfg_we) bin_width <= cfg_data;
  end

  lmp_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .stat
  );

  lmp_datapath u_dp (
    .clk, .rst, .cmd, .stat, .bin_width, .radius, .mu_value, .corr_value,
    .corr_error, .row_last, .radius_out, .monopole, .quadrupole,
    .hexadecapole, .mono_error, .quad_error, .hexa_error
  );

  `ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.emit, !out_valid)
  `ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid)
  `ASSERT_IMPLIES(a_no_take_busy, clk, rst, in_ready, !cmd.emit)

endmodule

// ----- design/lmp_datapath.sv -----
// ---------------------------------------------------------------------------
// lmp_datapath
// Weights, per-order products, saturating sums and a shared bit-serial
// square root (one result bit per cycle, three roots in parallel).
// ---------------------------------------------------------------------------
module lmp_datapath
  import lmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  lmp_cmd_t         cmd,
  output lmp_stat_t        stat,
  input  logic [16:0]      bin_width,
  input  logic [31:0]      radius,
  input  logic signed [17:0] mu_value,
  input  logic signed [31:0] corr_value,
  input  logic [30:0]      corr_error,
  input  logic             row_last,
  output logic [31:0]      radius_out,
  output logic signed [31:0] monopole,
  output logic signed [31:0] quadrupole,
  output logic signed [31:0] hexadecapole,
  output logic [31:0]      mono_error,
  output logic [31:0]      quad_error,
  output logic [31:0]      hexa_error
);

  localparam logic signed [47:0] SUM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] SUM_MIN = {1'b1, {47{1'b0}}};
  localparam logic signed [47:0] ONE     = 48'sd1 <<< FRAC_BITS;

  // Captured item
  logic [31:0]        radius_q;
  logic signed [17:0] mu;
  logic signed [31:0] corr;
  logic [30:0]        err;
  logic               last;

  // |mu| <= 2 keeps weights within 27 bits and k within 28 bits
  logic signed [47:0] m2, m4, w2, w4;
  logic signed [31:0] kval;
  logic [31:0]        kabs;
  logic signed [63:0] prod_s;
  logic [63:0]        prod_e;

  logic signed [47:0] sum [3];
  logic [63:0]        sq  [3];

  logic signed [31:0] wsel;
  logic signed [49:0] kprod;
  logic signed [47:0] tsum;
  logic [63:0]        tsq;
  logic [63:0]        e_sh;
  logic [31:0]        e_cl;

  // Square root state: remainder, root, step counter
  logic [63:0] rad [3];
  logic [31:0] root [3];
  logic [5:0]  step;

  assign stat.last      = last;
  assign stat.sqrt_done = (step == 6'(SQRT_STEPS));

  // Weight of the selected order
  always_comb begin
    case (cmd.sel)
      2'd0:    wsel = ONE[31:0];
      2'd1:    wsel = w2[31:0];
      2'd2:    wsel = w4[31:0];
      default: wsel = ONE[31:0];
    endcase
  end

  assign kprod = 50'(wsel) * 50'($signed({1'b0, bin_width}));
  assign e_sh  = prod_e >> FRAC_BITS;
  assign e_cl  = (e_sh > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e_sh[31:0];

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh7FFF_FFFF)       sat32 = 32'sh7FFF_FFFF;
    else if (v < -48'sh8000_0000) sat32 = 32'sh8000_0000;
    else                          sat32 = v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      radius_q <= radius;
      mu       <= mu_value;
      corr     <= corr_value;
      err      <= corr_error;
      last     <= row_last;
    end
    // Polynomial chain, one multiply a cycle
    if (cmd.poly1) m2 <= 48'((36'(mu) * 36'(mu)) >>> FRAC_BITS);
    if (cmd.poly2) m4 <= 48'((40'(m2[18:0]) * 40'(m2[18:0])) >> FRAC_BITS);
    if (cmd.weight) begin
      w2 <= (48'sd15 * m2 - 48'sd5 * ONE) >>> 1;
      w4 <= (48'sd315 * m4 - 48'sd270 * m2 + 48'sd27 * ONE) >>> 3;
    end
    if (cmd.kmul) begin
      kval <= 32'(kprod >>> FRAC_BITS);
      kabs <= (kprod[49]) ? 32'(-(kprod >>> FRAC_BITS)) : 32'(kprod >>> FRAC_BITS);
    end
    if (cmd.term) begin
      prod_s <= 64'(corr) * 64'(kval);
      prod_e <= 64'(err) * 64'(kabs);
    end
    if (cmd.acc) begin
      tsum <= 48'(prod_s >>> FRAC_BITS);
      tsq  <= 64'(e_cl) * 64'(e_cl);
    end
  end

  // Accumulate: registered terms land one state after ACC
  logic       acc_d;
  logic [1:0] sel_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_d <= 1'b0;
      sel_d <= '0;
    end else begin
      acc_d <= cmd.acc;
      sel_d <= cmd.sel;
    end
  end

  logic signed [48:0] add_s2;
  logic [64:0]        add_q2;
  assign add_s2 = 49'(sum[sel_d]) + 49'(tsum);
  assign add_q2 = {1'b0, sq[sel_d]} + {1'b0, tsq};

  logic signed [47:0] sum_next [3];
  logic [63:0]        sq_next  [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_next[i] = sum[i];
      sq_next[i]  = sq[i];
    end
    if (acc_d) begin
      if (add_s2 > 49'(SUM_MAX))      sum_next[sel_d] = SUM_MAX;
      else if (add_s2 < 49'(SUM_MIN)) sum_next[sel_d] = SUM_MIN;
      else                            sum_next[sel_d] = add_s2[47:0];
      sq_next[sel_d] = add_q2[64] ? {64{1'b1}} : add_q2[63:0];
    end
  end

  // Root steps hold off while the last order's sum update lands
  logic sqrt_go;
  assign sqrt_go = cmd.sqrt_step && !acc_d && (step != 6'(SQRT_STEPS));

  // Bit-serial square roots of the three error sums
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.sqrt_start) begin
      step <= '0;
    end else if (sqrt_go) begin
      step <= step + 6'd1;
    end
  end

  logic [63:0] rad_next  [3];
  logic [31:0] root_next [3];
  logic [65:0] trial     [3];
  logic [65:0] rem2      [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // bring down two bits of the operand (held in sq) each step
      rem2[i]   = {rad[i], 2'b00} | 66'((sq[i] >> (6'd62 - {step[4:0], 1'b0})) & 64'd3);
      trial[i]  = {32'd0, root[i], 2'b01};
      if (rem2[i] >= trial[i]) begin
        rad_next[i]  = 64'(rem2[i] - trial[i]);
        root_next[i] = {root[i][30:0], 1'b1};
      end else begin
        rad_next[i]  = rem2[i][63:0];
        root_next[i] = {root[i][30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.sqrt_start) begin
        rad[i]  <= '0;
        root[i] <= '0;
      end else if (sqrt_go) begin
        rad[i]  <= rad_next[i];
        root[i] <= root_next[i];
      end
    end
  end

  // Running sums, saturating; cleared at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        sq[i]  <= '0;
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
        sq[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        sum[i] <= sum_next[i];
        sq[i]  <= sq_next[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      radius_out   <= radius_q;
      monopole     <= sat32(sum[0]);
      quadrupole   <= sat32(sum[1]);
      hexadecapole <= sat32(sum[2]);
      mono_error   <= root[0];
      quad_error   <= root[1];
      hexa_error   <= root[2];
    end
  end

endmodule

// ----- design/lmp_ctrl.sv -----
// ---------------------------------------------------------------------------
// lmp_ctrl
// Sequencer: polynomial, three order passes, optional square root, output.
// ---------------------------------------------------------------------------
module lmp_ctrl
  import lmp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output lmp_cmd_t  cmd,
  input  lmp_stat_t stat
);

  lmp_state_t state, state_next;
  logic [1:0] sel, sel_next;
  logic       full, full_next;

  // Next state
  always_comb begin
    state_next = state;
    sel_next   = sel;
    case (state)
      ST_IDLE:   if (in_valid && in_ready) state_next = ST_POLY1;
      ST_POLY1:  state_next = ST_POLY2;
      ST_POLY2:  state_next = ST_WEIGHT;
      ST_WEIGHT: begin
        state_next = ST_KMUL;
        sel_next   = 2'd0;
      end
      ST_KMUL:   state_next = ST_TERM;
      ST_TERM:   state_next = ST_ACC;
      ST_ACC: begin
        if (sel == 2'd2) begin
          state_next = ST_SQRT;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = ST_KMUL;
        end
      end
      ST_SQRT: begin
        if (!stat.last) state_next = ST_IDLE;
        else if (stat.sqrt_done && !full) state_next = ST_OUT;
      end
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd        = '0;
    cmd.sel    = sel;
    in_ready   = (state == ST_IDLE);
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.poly1  = (state == ST_POLY1);
    cmd.poly2  = (state == ST_POLY2);
    cmd.weight = (state == ST_WEIGHT);
    cmd.kmul   = (state == ST_KMUL);
    cmd.term   = (state == ST_TERM);
    cmd.acc    = (state == ST_ACC);
    cmd.sqrt_start = (state == ST_ACC) && (sel == 2'd2);
    cmd.sqrt_step  = (state == ST_SQRT);
    cmd.emit   = (state == ST_OUT);
  end

  assign out_valid = full;
  always_comb begin
    full_next = full;
    if (out_valid && out_ready) full_next = 1'b0;
    if (state == ST_OUT) full_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel   <= '0;
      full  <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      full  <= full_next;
    end
  end

endmodule
